// File: src/gzsf_pkg.sv
// ----------------------------------------------------------------------------
// gzsf_pkg
// Shared types, constants and functions for the gzip stored block framer.
// ----------------------------------------------------------------------------
package gzsf_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] BLOCK_MAX  = 32'd65535;

  localparam logic [7:0]  GZ_ID1     = 8'h1F;
  localparam logic [7:0]  GZ_ID2     = 8'h8B;
  localparam logic [7:0]  GZ_CM      = 8'h08;
  localparam logic [7:0]  GZ_OS      = 8'h0B;

  // result slot positions within one request
  localparam logic [4:0]  SLOT_HDR   = 5'd0;
  localparam logic [4:0]  SLOT_HDR_L = 5'd9;
  localparam logic [4:0]  SLOT_BLK   = 5'd10;
  localparam logic [4:0]  SLOT_BLK_L = 5'd14;
  localparam logic [4:0]  SLOT_BYTE  = 5'd15;
  localparam logic [4:0]  SLOT_TRL   = 5'd16;
  localparam logic [4:0]  SLOT_TRL_L = 5'd23;

  typedef struct packed {
    logic        hdr;
    logic        blk;
    logic        blk_final;
    logic [15:0] blk_len;
    logic        byte_slot;
    logic [7:0]  byte_val;
    logic        err;
    logic        trl;
    logic [31:0] crc;
    logic [31:0] isize;
  } plan_t;

  function automatic logic [7:0] gz_lead(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = GZ_ID1;
      4'd1:    b = GZ_ID2;
      4'd2:    b = GZ_CM;
      4'd9:    b = GZ_OS;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] crc_fold(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/gzsf_emit.sv
// ----------------------------------------------------------------------------
// gzsf_emit
// Holds one request's plan and walks its result slots, one byte per cycle while
// the output is not stalled by result_ready, into a registered output stage.
// ----------------------------------------------------------------------------
module gzsf_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           plan_load,
  input  gzsf_pkg::plan_t plan_in,
  output logic           plan_free,
  output logic           result_valid,
  input  logic           result_ready,
  output logic [7:0]     out_byte,
  output logic           run_last,
  output logic           member_done,
  output logic           error_flag
);
  import gzsf_pkg::*;

  plan_t       plan;
  logic        plan_valid;
  logic [4:0]  pos;
  logic [4:0]  pos_next;
  logic [4:0]  pos_start;
  logic        last;
  logic        adv;
  logic [7:0]  cur_byte;
  logic [15:0] nlen;

  assign nlen = ~plan.blk_len;

  always_comb begin
    if (plan_in.hdr) begin
      pos_start = SLOT_HDR;
    end else if (plan_in.blk) begin
      pos_start = SLOT_BLK;
    end else if (plan_in.byte_slot) begin
      pos_start = SLOT_BYTE;
    end else begin
      pos_start = SLOT_TRL;
    end
  end

  always_comb begin
    pos_next = pos + 5'd1;
    last     = 1'b0;
    if (pos == SLOT_HDR_L) begin
      if (plan.blk) begin
        pos_next = SLOT_BLK;
      end else if (plan.byte_slot) begin
        pos_next = SLOT_BYTE;
      end else if (plan.trl) begin
        pos_next = SLOT_TRL;
      end else begin
        last = 1'b1;
      end
    end else if (pos == SLOT_BLK_L) begin
      if (plan.byte_slot) begin
        pos_next = SLOT_BYTE;
      end else if (plan.trl) begin
        pos_next = SLOT_TRL;
      end else begin
        last = 1'b1;
      end
    end else if (pos == SLOT_BYTE) begin
      last = !plan.trl;
    end else if (pos == SLOT_TRL_L) begin
      last = 1'b1;
    end
  end

  always_comb begin
    unique case (pos)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4,
      5'd5, 5'd6, 5'd7, 5'd8, 5'd9: cur_byte = gz_lead(pos[3:0]);
      5'd10:   cur_byte = {7'd0, plan.blk_final};
      5'd11:   cur_byte = plan.blk_len[7:0];
      5'd12:   cur_byte = plan.blk_len[15:8];
      5'd13:   cur_byte = nlen[7:0];
      5'd14:   cur_byte = nlen[15:8];
      5'd15:   cur_byte = plan.byte_val;
      5'd16:   cur_byte = plan.crc[7:0];
      5'd17:   cur_byte = plan.crc[15:8];
      5'd18:   cur_byte = plan.crc[23:16];
      5'd19:   cur_byte = plan.crc[31:24];
      5'd20:   cur_byte = plan.isize[7:0];
      5'd21:   cur_byte = plan.isize[15:8];
      5'd22:   cur_byte = plan.isize[23:16];
      5'd23:   cur_byte = plan.isize[31:24];
      default: cur_byte = 8'h00;
    endcase
  end

  assign adv       = plan_valid && (!result_valid || result_ready);
  assign plan_free = !plan_valid || (adv && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
    end else if (plan_free) begin
      plan_valid <= plan_load;
    end
  end

  always_ff @(posedge clk) begin
    if (plan_free && plan_load) begin
      plan <= plan_in;
      pos  <= pos_start;
    end else if (adv) begin
      pos  <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte    <= cur_byte;
      run_last    <= last;
      member_done <= (pos == SLOT_TRL_L);
      error_flag  <= (pos == SLOT_BYTE) && plan.err;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && member_done |-> run_last)
    else $error("member end not marked as last result");

  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && error_flag |-> run_last && !member_done && (out_byte == 8'h00))
    else $error("error result malformed");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    plan_valid |-> pos <= SLOT_TRL_L)
    else $error("slot position out of range");
`endif

endmodule

// File: src/gzip_stored_block_framer.sv
// ----------------------------------------------------------------------------
// gzip_stored_block_framer
// Frames a byte stream as one gzip member of stored deflate blocks with CRC-32.
// A request is held in the emitter's plan register; its results leave through the output register.
// Throughput: a request yields 1 to 24 results, one per cycle while the output is not
// stalled; payload bytes inside a block stream at one per cycle under that condition.
// Reset: synchronous, clears stream_length, counters and all valids, and sets the CRC to CRC_INIT.
// ----------------------------------------------------------------------------
module gzip_stored_block_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        member_done,
  output logic        error_flag
);
  import gzsf_pkg::*;

  logic [31:0] stream_length;
  logic [31:0] crc_acc;
  logic [31:0] bytes_taken;
  logic [15:0] blk_left;
  logic        header_sent;

  logic [31:0] crc_acc_next;
  logic [31:0] bytes_taken_next;
  logic [15:0] blk_left_next;
  logic        header_sent_next;

  logic        accept;
  logic [31:0] remaining;
  logic [31:0] blk_n;
  logic [15:0] left_cur;
  logic [31:0] crc_new;
  logic [31:0] taken_new;
  logic [15:0] left_new;
  plan_t       plan;

  assign accept    = item_valid && item_ready;
  assign remaining = (stream_length > bytes_taken) ? (stream_length - bytes_taken) : 32'd0;
  assign blk_n     = (remaining < BLOCK_MAX) ? remaining : BLOCK_MAX;
  assign left_cur  = (blk_left == 16'd0) ? blk_n[15:0] : blk_left;
  assign left_new  = left_cur - 16'd1;
  assign crc_new   = crc_fold(crc_acc, data_byte);
  assign taken_new = bytes_taken + 32'd1;

  always_comb begin
    plan             = '0;
    crc_acc_next     = crc_acc;
    bytes_taken_next = bytes_taken;
    blk_left_next    = blk_left;
    header_sent_next = header_sent;
    if (!has_byte) begin
      if (!header_sent && (stream_length == 32'd0)) begin
        plan.hdr       = 1'b1;
        plan.blk       = 1'b1;
        plan.blk_final = 1'b1;
        plan.trl       = 1'b1;
      end else begin
        plan.byte_slot = 1'b1;
        plan.err       = 1'b1;
      end
    end else if ((blk_left == 16'd0) && (remaining == 32'd0)) begin
      plan.byte_slot = 1'b1;
      plan.err       = 1'b1;
    end else begin
      plan.hdr       = !header_sent;
      plan.blk       = (blk_left == 16'd0);
      plan.blk_final = (blk_n >= remaining);
      plan.blk_len   = blk_n[15:0];
      plan.byte_slot = 1'b1;
      plan.byte_val  = data_byte;
      plan.crc       = ~crc_new;
      plan.isize     = taken_new;
      plan.trl       = (left_new == 16'd0) && (taken_new >= stream_length);
      blk_left_next  = left_new;
      if (plan.trl) begin
        crc_acc_next     = CRC_INIT;
        bytes_taken_next = 32'd0;
        header_sent_next = 1'b0;
      end else begin
        crc_acc_next     = crc_new;
        bytes_taken_next = taken_new;
        header_sent_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length <= 32'd0;
    end else if (cfg_wr_en) begin
      stream_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc     <= CRC_INIT;
      bytes_taken <= 32'd0;
      blk_left    <= 16'd0;
      header_sent <= 1'b0;
    end else if (accept) begin
      crc_acc     <= crc_acc_next;
      bytes_taken <= bytes_taken_next;
      blk_left    <= blk_left_next;
      header_sent <= header_sent_next;
    end
  end

  gzsf_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .plan_load    (item_valid),
    .plan_in      (plan),
    .plan_free    (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .member_done  (member_done),
    .error_flag   (error_flag)
  );

`ifndef NO_ASSERTIONS
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(bytes_taken) && $stable(blk_left) && $stable(crc_acc))
    else $error("framer state changed without a request");

  a_idle_on_end: assert property (@(posedge clk) disable iff (rst)
    $fell(header_sent) |-> (bytes_taken == 32'd0) && (crc_acc == CRC_INIT))
    else $error("member end left stale state");

  a_block_within_member: assert property (@(posedge clk) disable iff (rst)
    !header_sent |-> (blk_left == 16'd0) && (bytes_taken == 32'd0))
    else $error("block open outside a member");
`endif

endmodule
